/* hdl/cpt_pkg.sv */
// Shared constants and types for the capability policy table.
package cpt_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam int KEY_W  = 16;
  localparam int CAPS_W = 64;
  localparam int FUNC_W = 2;
  localparam int STAT_W = 3;
  localparam int OCNT_W = 5;

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 144;
  localparam int CFG_IDX_W  = 2;

  localparam logic [FUNC_W-1:0] FUNC_REGISTER = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_UPDATE   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_EVALUATE = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP   = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
  localparam logic [STAT_W-1:0] ST_INVAL = 3'd1;
  localparam logic [STAT_W-1:0] ST_DUP   = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 3'd3;
  localparam logic [STAT_W-1:0] ST_NODEV = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_VALID_CAPS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RISKY_CAPS = 2'd1;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [CAPS_W-1:0] allowed;
    logic              gated;
  } entry_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  node_id;
    logic [CAPS_W-1:0] caps;
    logic              gate_on_health;
    logic              health_stable;
    logic              risky_io_ok;
  } req_t;

  // Clamp an entry count to the five-bit result field.
  function automatic logic [OCNT_W-1:0] sat_count(input logic [CNT_W-1:0] cnt);
    logic [31:0] wide;
    wide = 32'(cnt);
    return (wide > 32'd31) ? 5'd31 : wide[OCNT_W-1:0];
  endfunction

endpackage

/* hdl/capability_policy_table_top.sv */
// Capability policy table: entry memory, scan sequencer and result register.
//
// Each request word goes through the scan, drain and execute states, in that order,
// from acceptance to the edge that loads its result word. This sequence is set by
// the single read port of the entry memory: the sequencer reads one entry a cycle,
// in slot order, and folds it into the key match, the lowest free slot and the
// active and risky counts; the drain state covers the registered read, and the
// execute state applies the operation, writes the memory and loads the result
// register. The sequencer then returns to idle, and only there can it accept the
// next request word, so a request word is accepted only after the previous one has
// been executed. The execute state waits while an earlier result word is still held
// by out_tready low. A new request word is accepted whenever
// the sequencer is idle, even while an earlier result word still waits on
// out_tready. The entry memory needs no clearing pass: per-slot valid bits in
// flip-flops are cleared by reset. Configuration words are always accepted
// (cfg_ready is high); indexes other than the two defined registers are ignored.
module capability_policy_table_top
  import cpt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Request channel.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // in_tdata, low bit up: node_id[15:0], caps[79:16], gate_on_health[80],
  // health_stable[81], risky_io_ok[82], zero pad[87:83].
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: func[1:0].
  input  logic [FUNC_W-1:0]     in_tuser,
  // Result channel.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_tdata, low bit up: status[2:0], permit[3], health_block[4],
  // grant_mask[68:5], entry_caps[132:69], entry_gate[133],
  // active_count[138:134], risky_count[143:139].
  output logic [OUT_DATA_W-1:0] out_tdata,
  // Configuration write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CAPS_W-1:0]     cfg_data
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_EXEC  = 2'd3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  logic [1:0]              state_r, state_nxt;
  logic [IDX_W-1:0]        addr_r;
  req_t                    req_r;
  logic [CAPS_W-1:0]       valid_mask_r, risky_mask_r;
  logic [TABLE_ENTRIES-1:0] valid_r;

  // Entry memory with a registered read port.
  entry_t                  mem [TABLE_ENTRIES];
  entry_t                  rd_data_r;
  logic                    rd_vld_r;
  logic                    rd_valid_bit_r;
  logic [IDX_W-1:0]        rd_idx_r;

  // Scan accumulators.
  logic                    found_r;
  logic [IDX_W-1:0]        hit_idx_r;
  logic [CAPS_W-1:0]       hit_allowed_r;
  logic                    hit_gated_r;
  logic                    free_found_r;
  logic [IDX_W-1:0]        free_idx_r;
  logic [CNT_W-1:0]        active_cnt_r;
  logic [CNT_W-1:0]        risky_cnt_r;

  logic                    out_tvalid_r;
  logic [OUT_DATA_W-1:0]   out_tdata_r;

  logic                    in_fire;
  logic                    exec_go;

  // Operation decode in the execute cycle.
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  entry_t                  wr_data;
  logic                    set_valid;
  logic [STAT_W-1:0]       status;
  logic                    permit, blocked;
  logic [CAPS_W-1:0]       granted, ecaps;
  logic                    egate;
  logic [CNT_W-1:0]        active_new, risky_new;
  logic                    inval, req_risky, old_risky;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign exec_go    = (state_r == S_EXEC) && (!out_tvalid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_SCAN;
      S_SCAN:  if (addr_r == LAST_IDX) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_EXEC;
      S_EXEC:  if (exec_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    inval      = (req_r.caps & ~valid_mask_r) != '0;
    req_risky  = (req_r.caps & risky_mask_r) != '0;
    old_risky  = (hit_allowed_r & risky_mask_r) != '0;
    wr_en      = 1'b0;
    wr_addr    = free_idx_r;
    wr_data    = '{key: req_r.node_id, allowed: req_r.caps, gated: req_r.gate_on_health};
    set_valid  = 1'b0;
    status     = ST_OK;
    permit     = 1'b0;
    blocked    = 1'b0;
    granted    = '0;
    ecaps      = '0;
    egate      = 1'b0;
    active_new = active_cnt_r;
    risky_new  = risky_cnt_r;
    unique case (req_r.func)
      FUNC_REGISTER: begin
        if (inval) begin
          status = ST_INVAL;
        end else if (found_r) begin
          status = ST_DUP;
        end else if (!free_found_r) begin
          status = ST_FULL;
        end else begin
          wr_en      = 1'b1;
          set_valid  = 1'b1;
          active_new = active_cnt_r + CNT_W'(1);
          risky_new  = risky_cnt_r + CNT_W'(req_risky);
        end
      end
      FUNC_UPDATE: begin
        if (inval) begin
          status = ST_INVAL;
        end else if (!found_r) begin
          status = ST_NODEV;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = hit_idx_r;
          wr_data   = '{key: req_r.node_id, allowed: req_r.caps, gated: hit_gated_r};
          risky_new = risky_cnt_r - CNT_W'(old_risky) + CNT_W'(req_risky);
        end
      end
      FUNC_EVALUATE: begin
        if (!found_r) begin
          status = ST_NODEV;
        end else if ((req_r.caps & ~hit_allowed_r) != '0) begin
          permit = 1'b0;
        end else if (hit_gated_r && req_risky &&
                     !(req_r.health_stable && req_r.risky_io_ok)) begin
          blocked = 1'b1;
        end else begin
          permit  = 1'b1;
          granted = req_r.caps;
        end
      end
      FUNC_LOOKUP: begin
        if (!found_r) begin
          status = ST_NODEV;
        end else begin
          ecaps = hit_allowed_r;
          egate = hit_gated_r;
        end
      end
      default: status = ST_OK;
    endcase
  end

  // Memory: written only in the execute cycle, and read data is used only while
  // scanning, so a write never meets a read whose data counts.
  always_ff @(posedge clk) begin
    if (exec_go && wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r      <= mem[addr_r];
    rd_valid_bit_r <= valid_r[addr_r];
    rd_idx_r       <= addr_r;
    if (in_fire) begin
      req_r <= '{func: in_tuser, node_id: in_tdata[15:0], caps: in_tdata[79:16],
                 gate_on_health: in_tdata[80], health_stable: in_tdata[81],
                 risky_io_ok: in_tdata[82]};
    end
    if (in_fire) begin
      hit_idx_r     <= '0;
      hit_allowed_r <= '0;
      hit_gated_r   <= 1'b0;
      free_idx_r    <= '0;
    end else if (rd_vld_r) begin
      if (rd_valid_bit_r && rd_data_r.key == req_r.node_id && !found_r) begin
        hit_idx_r     <= rd_idx_r;
        hit_allowed_r <= rd_data_r.allowed;
        hit_gated_r   <= rd_data_r.gated;
      end
      if (!rd_valid_bit_r && !free_found_r) begin
        free_idx_r <= rd_idx_r;
      end
    end
    if (exec_go) begin
      out_tdata_r <= {sat_count(risky_new), sat_count(active_new), egate, ecaps,
                      granted, blocked, permit, status};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      addr_r       <= '0;
      rd_vld_r     <= 1'b0;
      valid_r      <= '0;
      valid_mask_r <= '1;
      risky_mask_r <= '0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      active_cnt_r <= '0;
      risky_cnt_r  <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= (state_r == S_SCAN);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_VALID_CAPS) valid_mask_r <= cfg_data;
        if (cfg_index == CFG_RISKY_CAPS) risky_mask_r <= cfg_data;
      end
      if (in_fire) begin
        addr_r <= '0;
      end else if (state_r == S_SCAN && addr_r != LAST_IDX) begin
        addr_r <= addr_r + IDX_W'(1);
      end
      if (in_fire) begin
        found_r      <= 1'b0;
        free_found_r <= 1'b0;
        active_cnt_r <= '0;
        risky_cnt_r  <= '0;
      end else if (rd_vld_r) begin
        if (rd_valid_bit_r) begin
          active_cnt_r <= active_cnt_r + CNT_W'(1);
          if ((rd_data_r.allowed & risky_mask_r) != '0) begin
            risky_cnt_r <= risky_cnt_r + CNT_W'(1);
          end
          if (rd_data_r.key == req_r.node_id) found_r <= 1'b1;
        end else begin
          free_found_r <= 1'b1;
        end
      end
      if (exec_go && set_valid) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (exec_go) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the capability policy table top level.
`timescale 1ns / 100ps

module tb_top;
  import cpt_pkg::*;

  // SCAN_LATENCY sizes the quiet time at the end of the run.
  localparam int SCAN_LATENCY = TABLE_ENTRIES + 3;
  // The block does not map this configuration index. A write to it must change
  // nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int WORDS_PER_PHASE = 200;

  // Expected content of one result word, unpacked into its fields.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              permit;
    logic              blocked;
    logic [CAPS_W-1:0] granted;
    logic [CAPS_W-1:0] held_caps;
    logic              held_gate;
    logic [OCNT_W-1:0] active;
    logic [OCNT_W-1:0] risky;
  } verdict_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  // in_tdata, low bit up: node_id, caps, gate_on_health, health_stable,
  // risky_io_ok, zero pad.
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  // in_tuser: func.
  logic [FUNC_W-1:0]     in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // out_tdata, low bit up: status, permit, health_block, grant_mask,
  // entry_caps, entry_gate, active_count, risky_count.
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CAPS_W-1:0]     cfg_data   = '0;

  // This is the predictor's own copy of the policy table and of the two mask registers.
  logic              tbl_valid   [TABLE_ENTRIES];
  logic [KEY_W-1:0]  tbl_key     [TABLE_ENTRIES];
  logic [CAPS_W-1:0] tbl_allowed [TABLE_ENTRIES];
  logic              tbl_gated   [TABLE_ENTRIES];
  logic [CAPS_W-1:0] valid_caps = '1;
  logic [CAPS_W-1:0] risky_caps = '0;

  // This queue holds the verdicts of accepted requests in the order of acceptance. The
  // block answers strictly in that order.
  verdict_t awaited_verdicts[$];

  int  mismatch_count = 0;
  int  result_no      = 0;
  int  traffic_phase  = 0;
  int  rx_hold        = 0;
  bit  rx_stall_en    = 1'b0;
  bit  tx_idle_en     = 1'b0;

  capability_policy_table_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The slowest correct run has about 1700 words. The watchdog is sized so that
  // every word may meet a full sender gap, the scan and a full receiver stall.
  initial begin
    #10_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Returns the slot that holds a valid entry for this key, or -1 if there is none.
  function automatic int find_slot(input logic [KEY_W-1:0] key);
    int i;
    for (i = 0; i < TABLE_ENTRIES; i++) begin
      if (tbl_valid[i] && tbl_key[i] == key) return i;
    end
    return -1;
  endfunction

  // This function applies one request to the predictor's table. It returns the result
  // word that the block should produce for that request.
  function automatic verdict_t judge_request(input req_t r);
    verdict_t v;
    int       slot;
    int       spare;
    int       active_n;
    int       risky_n;
    int       i;
    v = '0;
    slot = find_slot(r.node_id);
    spare = -1;
    for (i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (!tbl_valid[i]) spare = i;
    end
    case (r.func)
      FUNC_REGISTER: begin
        // The mask check comes first, then the duplicate check, then the capacity check.
        if ((r.caps & ~valid_caps) != '0) v.status = ST_INVAL;
        else if (slot >= 0) v.status = ST_DUP;
        else if (spare < 0) v.status = ST_FULL;
        else begin
          v.status = ST_OK;
          tbl_valid[spare]   = 1'b1;
          tbl_key[spare]     = r.node_id;
          tbl_allowed[spare] = r.caps;
          tbl_gated[spare]   = r.gate_on_health;
        end
      end
      FUNC_UPDATE: begin
        if ((r.caps & ~valid_caps) != '0) v.status = ST_INVAL;
        else if (slot < 0) v.status = ST_NODEV;
        else tbl_allowed[slot] = r.caps;
      end
      FUNC_EVALUATE: begin
        if (slot < 0) v.status = ST_NODEV;
        else if ((r.caps & tbl_allowed[slot]) != r.caps) v.permit = 1'b0;
        else if (tbl_gated[slot] && (r.caps & risky_caps) != '0 &&
                 !(r.health_stable && r.risky_io_ok)) v.blocked = 1'b1;
        else begin
          v.permit  = 1'b1;
          v.granted = r.caps;
        end
      end
      FUNC_LOOKUP: begin
        if (slot < 0) v.status = ST_NODEV;
        else begin
          v.held_caps = tbl_allowed[slot];
          v.held_gate = tbl_gated[slot];
        end
      end
    endcase
    active_n = 0;
    risky_n = 0;
    for (i = 0; i < TABLE_ENTRIES; i++) begin
      if (tbl_valid[i]) begin
        active_n++;
        if ((tbl_allowed[i] & risky_caps) != '0) risky_n++;
      end
    end
    v.active = OCNT_W'(active_n > 31 ? 31 : active_n);
    v.risky  = OCNT_W'(risky_n > 31 ? 31 : risky_n);
    return v;
  endfunction

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input logic [CAPS_W-1:0] got,
                               input logic [CAPS_W-1:0] want);
    if (got !== want) begin
      flag_error($sformatf("result %0d %s: got %h, expected %h", result_no, name, got, want));
    end
  endtask

  // This task checks one accepted result word against the oldest verdict that waits.
  task automatic check_result(input logic [OUT_DATA_W-1:0] word);
    verdict_t want;
    if (awaited_verdicts.size() == 0) begin
      flag_error($sformatf("result word %h arrived with nothing expected", word));
      return;
    end
    want = awaited_verdicts.pop_front();
    compare_field("status",       CAPS_W'(word[2:0]),     CAPS_W'(want.status));
    compare_field("permit",       CAPS_W'(word[3]),       CAPS_W'(want.permit));
    compare_field("health_block", CAPS_W'(word[4]),       CAPS_W'(want.blocked));
    compare_field("grant_mask",   word[68:5],             want.granted);
    compare_field("entry_caps",   word[132:69],           want.held_caps);
    compare_field("entry_gate",   CAPS_W'(word[133]),     CAPS_W'(want.held_gate));
    compare_field("active_count", CAPS_W'(word[138:134]), CAPS_W'(want.active));
    compare_field("risky_count",  CAPS_W'(word[143:139]), CAPS_W'(want.risky));
    result_no++;
  endtask

  // This process is the result side. It checks every word that it accepts. It also drops
  // out_tready in random bursts while stalls are enabled.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_result(out_tdata);
    if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold    <= rx_hold - 1;
    end else begin
      out_tready <= 1'b1;
      if (rx_stall_en && $urandom_range(0, 5) == 0) rx_hold <= $urandom_range(1, 10);
    end
  end

  // This task sends one request word and records its verdict at the edge where the
  // block accepts it. On return, in_tvalid stays high. The next call, or wait_drain,
  // decides its level in this same time step, so in_tvalid never gets two updates here.
  task automatic send_request(input req_t r);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.func;
    in_tdata  <= {5'b0, r.risky_io_ok, r.health_stable, r.gate_on_health, r.caps, r.node_id};
    do @(posedge clk); while (!in_tready);
    awaited_verdicts.push_back(judge_request(r));
  endtask

  task automatic issue(input logic [FUNC_W-1:0] func, input logic [KEY_W-1:0] key,
                       input logic [CAPS_W-1:0] caps, input bit gate, input bit stable,
                       input bit io_ok);
    req_t r;
    r.func           = func;
    r.node_id        = key;
    r.caps           = caps;
    r.gate_on_health = gate;
    r.health_stable  = stable;
    r.risky_io_ok    = io_ok;
    send_request(r);
  endtask

  // This task stops the sender and waits until every outstanding result word has come
  // back. After that the block is idle and can take configuration writes.
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (awaited_verdicts.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // This task writes both mask registers back to back and then writes the unmapped
  // index, which the block must ignore. cfg_valid stays high across the three words.
  task automatic set_masks(input logic [CAPS_W-1:0] valid_m, input logic [CAPS_W-1:0] risky_m);
    logic [CFG_IDX_W-1:0] idx [3];
    logic [CAPS_W-1:0]    val [3];
    int                   i;
    idx[0] = CFG_VALID_CAPS;
    idx[1] = CFG_RISKY_CAPS;
    idx[2] = CFG_SPARE;
    val[0] = valid_m;
    val[1] = risky_m;
    val[2] = rand64();
    for (i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx[i])
        CFG_VALID_CAPS: valid_caps = val[i];
        CFG_RISKY_CAPS: risky_caps = val[i];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // This function builds a random request. Most requests address the node held in a
  // randomly drawn slot when that slot is valid, so that updates, evaluations and
  // lookups reach a stored entry. Most masks are drawn from inside the valid mask, or from
  // inside the entry's allowed mask for evaluations, so the paths past the first checks are taken.
  function automatic req_t random_request();
    req_t              r;
    int                slot;
    int                roll;
    bit                known;
    logic [CAPS_W-1:0] base;
    r.func = FUNC_W'($urandom_range(0, 3));
    slot = $urandom_range(0, TABLE_ENTRIES - 1);
    roll = $urandom_range(0, 99);
    known = (roll < 75) && tbl_valid[slot];
    if (known) r.node_id = tbl_key[slot];
    else if (roll < 80) r.node_id = '1;
    else if (roll < 85) r.node_id = '0;
    else r.node_id = KEY_W'($urandom);
    base = (r.func == FUNC_EVALUATE && known) ? tbl_allowed[slot] : valid_caps;
    roll = $urandom_range(0, 99);
    if (roll < 25) r.caps = rand64() & rand64() & base;
    else if (roll < 55) r.caps = rand64() & base;
    else if (roll < 65) r.caps = '0;
    else if (roll < 72) r.caps = '1;
    else r.caps = rand64();
    r.gate_on_health = 1'($urandom_range(0, 1));
    r.health_stable  = $urandom_range(0, 3) != 0;
    r.risky_io_ok    = $urandom_range(0, 3) != 0;
    return r;
  endfunction

  // With the masks at their reset values, every access to the empty table reports an
  // unknown node.
  task automatic test_empty_table();
    issue(FUNC_LOOKUP,   16'h0000, '0,     1'b0, 1'b0, 1'b0);
    issue(FUNC_EVALUATE, 16'hFFFF, '1,     1'b1, 1'b1, 1'b1);
    issue(FUNC_UPDATE,   16'h1234, 64'h5,  1'b0, 1'b0, 1'b0);
  endtask

  // This test checks the order in which register and update detect their errors, and
  // writes the two entries that the evaluate test relies on.
  task automatic test_register_rules();
    logic [CAPS_W-1:0] vm;
    vm = 64'h00FF_FFFF_FFFF_FFFF;
    wait_drain();
    set_masks(vm, 64'h4000_0000_0000_00F0);
    issue(FUNC_REGISTER, 16'h0000, vm,     1'b1, 1'b0, 1'b0);
    issue(FUNC_REGISTER, 16'hFFFF, '0,     1'b0, 1'b0, 1'b0);
    issue(FUNC_REGISTER, 16'h0001, 64'h8000_0000_0000_0000, 1'b0, 1'b0, 1'b0);
    // This word reuses a present id. Its mask is valid, so it must fail as a duplicate.
    issue(FUNC_REGISTER, 16'h0000, 64'h1,  1'b0, 1'b0, 1'b0);
    // This word reuses a present id with an invalid mask. The mask check comes first.
    issue(FUNC_REGISTER, 16'h0000, 64'h8000_0000_0000_0000, 1'b0, 1'b0, 1'b0);
    // An update with an invalid mask fails on the mask, even when the node is unknown.
    issue(FUNC_UPDATE,   16'hABCD, 64'h8000_0000_0000_0000, 1'b0, 1'b0, 1'b0);
    issue(FUNC_UPDATE,   16'hABCD, 64'h1,  1'b0, 1'b0, 1'b0);
    issue(FUNC_UPDATE,   16'hFFFF, 64'hF0F, 1'b0, 1'b0, 1'b0);
    issue(FUNC_LOOKUP,   16'h0000, '0,     1'b0, 1'b0, 1'b0);
    issue(FUNC_LOOKUP,   16'hFFFF, '1,     1'b1, 1'b1, 1'b1);
  endtask

  // Node 0000 is gated and allows every valid bit. Node FFFF is not gated and allows
  // 0xF0F. Only the allowed mask of node 0000 meets the risky mask.
  task automatic test_evaluate_rules();
    int i;
    // A risky request to the gated entry passes only when both health inputs are set.
    for (i = 0; i < 4; i++) begin
      issue(FUNC_EVALUATE, 16'h0000, 64'h10, 1'b0, i[0], i[1]);
    end
    issue(FUNC_EVALUATE, 16'h0000, 64'h100, 1'b0, 1'b0, 1'b0);
    // An empty request is always a subset. With no risky bits, no gate applies.
    issue(FUNC_EVALUATE, 16'h0000, '0,      1'b0, 1'b0, 1'b0);
    issue(FUNC_EVALUATE, 16'h0000, 64'h8000_0000_0000_0000, 1'b0, 1'b1, 1'b1);
    // This request is not a subset and would also fail the gate. Denial as a non-subset
    // wins, so it must not be flagged as blocked by health.
    issue(FUNC_EVALUATE, 16'h0000, 64'h8000_0000_0000_0010, 1'b0, 1'b0, 1'b0);
    issue(FUNC_EVALUATE, 16'hFFFF, 64'h10,   1'b0, 1'b0, 1'b0);
    issue(FUNC_EVALUATE, 16'hFFFF, 64'h1000, 1'b0, 1'b1, 1'b1);
    issue(FUNC_EVALUATE, 16'h0000, 64'h00FF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 1'b1);
  endtask

  // This test fills any free slots with fresh ids, then checks a full table. A fresh id
  // must report the table full. A present id must still report a duplicate.
  task automatic test_table_full();
    logic [KEY_W-1:0] key;
    int               i;
    for (i = 0; i < TABLE_ENTRIES; i++) begin
      if (!tbl_valid[i]) begin
        do key = KEY_W'($urandom); while (find_slot(key) >= 0);
        issue(FUNC_REGISTER, key, rand64() & valid_caps, 1'($urandom_range(0, 1)),
              1'b0, 1'b0);
      end
    end
    do key = KEY_W'($urandom); while (find_slot(key) >= 0);
    issue(FUNC_REGISTER, key, valid_caps & rand64(), 1'b1, 1'b0, 1'b0);
    issue(FUNC_REGISTER, tbl_key[TABLE_ENTRIES-1], '0, 1'b0, 1'b0, 1'b0);
  endtask

  // This test runs random traffic in phases. Each phase starts on an idle block with a
  // new mask setting. The settings rotate through the extremes and random masks. Idling
  // on each side is switched per phase. A calm finish runs the last phase with no idling.
  task automatic test_random_traffic(input int phases, input bit calm_finish);
    logic [CAPS_W-1:0] vm;
    logic [CAPS_W-1:0] rm;
    int                p;
    int                n;
    for (p = 0; p < phases; p++) begin
      wait_drain();
      case (traffic_phase % 6)
        0: begin vm = '1; rm = '1; end
        1: begin vm = '0; rm = '0; end
        2: begin vm = rand64(); rm = rand64() & rand64() & rand64(); end
        3: begin vm = '1; rm = 64'h1 << $urandom_range(0, 63); end
        4: begin vm = rand64() | rand64(); rm = rand64(); end
        default: begin vm = ~(64'h1 << $urandom_range(0, 63)); rm = rand64() & rand64(); end
      endcase
      traffic_phase++;
      set_masks(vm, rm);
      if (calm_finish && p == phases - 1) begin
        tx_idle_en  = 1'b0;
        rx_stall_en <= 1'b0;
      end else begin
        tx_idle_en  = $urandom_range(0, 3) != 0;
        rx_stall_en <= $urandom_range(0, 3) != 0;
      end
      for (n = 0; n < WORDS_PER_PHASE; n++) send_request(random_request());
    end
  endtask

  initial begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      tbl_valid[i]   = 1'b0;
      tbl_key[i]     = '0;
      tbl_allowed[i] = '0;
      tbl_gated[i]   = 1'b0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_register_rules();
    test_evaluate_rules();
    test_random_traffic(3, 1'b0);
    test_table_full();
    test_random_traffic(5, 1'b1);

    // Wait until every result word is back, then let the block sit idle for a quiet time
    // sized by SCAN_LATENCY. Any stray result word that appears in that time is reported.
    wait_drain();
    repeat (2 * SCAN_LATENCY) @(posedge clk);
    if (awaited_verdicts.size() != 0) begin
      flag_error($sformatf("%0d result words never arrived", awaited_verdicts.size()));
    end
    if (mismatch_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
